// ===== hdl/qmr_pkg.sv =====
// ----------------------------------------------------------------------------
// qmr_pkg
// Shared types, constants and rounding helper for the quaternion unit.
// ----------------------------------------------------------------------------
package qmr_pkg;

   localparam int FRAC_BITS  = 12;
   localparam int COMP_W     = 16;
   localparam int WIDE_W     = COMP_W + 1;
   localparam int PROD_W     = COMP_W + WIDE_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam int RND_W      = SUM_W + 1;
   localparam int NUM_COMP   = 4;

   localparam int CX = 0;
   localparam int CY = 1;
   localparam int CZ = 2;
   localparam int CW = 3;

   typedef enum logic {
      OP_MULTIPLY = 1'b0,
      OP_ROTATE   = 1'b1
   } op_type;

   typedef logic [NUM_COMP-1:0][COMP_W-1:0]               quat_type;
   typedef logic [NUM_COMP-1:0][WIDE_W-1:0]               wquat_type;
   typedef logic [NUM_COMP-1:0][NUM_COMP-1:0][PROD_W-1:0] prod_arr_type;

   typedef struct packed {
      op_type   opcode;
      quat_type a;
      logic     sat;
   } side_type;

   typedef struct packed {
      logic [COMP_W-1:0] value;
      logic              sat;
   } rnd_type;

   localparam logic signed [WIDE_W-1:0] ONE_VAL  = WIDE_W'(1 << FRAC_BITS);
   localparam logic signed [RND_W-1:0]  RND_BIAS = RND_W'(1 << (FRAC_BITS - 1));
   localparam logic signed [RND_W-1:0]  MAX_VAL  = RND_W'((1 << (COMP_W - 1)) - 1);
   localparam logic signed [RND_W-1:0]  MIN_VAL  = -RND_W'(1 << (COMP_W - 1));

   // round half up at FRAC_BITS, then clamp to 16 bits
   function automatic rnd_type round_sat(input logic signed [SUM_W-1:0] s);
      logic signed [RND_W-1:0] t;
      rnd_type                 r;
      t = (RND_W'(s) + RND_BIAS) >>> FRAC_BITS;
      if (t > MAX_VAL) begin
         r.value = MAX_VAL[COMP_W-1:0];
         r.sat   = 1'b1;
      end else if (t < MIN_VAL) begin
         r.value = MIN_VAL[COMP_W-1:0];
         r.sat   = 1'b1;
      end else begin
         r.value = t[COMP_W-1:0];
         r.sat   = 1'b0;
      end
      return r;
   endfunction

endpackage

// ===== hdl/qmr_if.sv =====
// ----------------------------------------------------------------------------
// qmr_if
// Request and response channels of the quaternion unit.
// ----------------------------------------------------------------------------
interface qmr_req_if;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic signed [15:0] a_x;
   logic signed [15:0] a_y;
   logic signed [15:0] a_z;
   logic signed [15:0] a_w;
   logic signed [15:0] b_x;
   logic signed [15:0] b_y;
   logic signed [15:0] b_z;
   logic signed [15:0] b_w;

   modport source (output valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                   input ready);
   modport sink   (input valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                   output ready);
endinterface

interface qmr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] res_x;
   logic signed [15:0] res_y;
   logic signed [15:0] res_z;
   logic signed [15:0] res_w;
   logic               saturated;

   modport source (output valid, res_x, res_y, res_z, res_w, saturated,
                   input ready);
   modport sink   (input valid, res_x, res_y, res_z, res_w, saturated,
                   output ready);
endinterface

// ===== hdl/qmr_mul.sv =====
// ----------------------------------------------------------------------------
// qmr_mul
// Pipeline stage forming all sixteen cross products of two quaternions.
// ----------------------------------------------------------------------------
module qmr_mul import qmr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         valid_in,
   output logic         ready_out,
   input  quat_type     p,
   input  wquat_type    q,
   input  side_type     side_in,
   output logic         valid_out,
   input  logic         ready_in,
   output prod_arr_type prod_out,
   output side_type     side_out
);

   logic         valid_ff;
   prod_arr_type prod_ff, prod_in;
   side_type     side_ff;
   logic         enable;

   assign enable    = !valid_ff || ready_in;
   assign ready_out = enable;

   always_comb begin
      for (int i = 0; i < NUM_COMP; i++) begin
         for (int j = 0; j < NUM_COMP; j++) begin
            prod_in[i][j] = PROD_W'($signed(p[i]) * $signed(q[j]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && valid_in) begin
         prod_ff <= prod_in;
         side_ff <= side_in;
      end
   end

   assign valid_out = valid_ff;
   assign prod_out  = prod_ff;
   assign side_out  = side_ff;

endmodule

// ===== hdl/qmr_sum.sv =====
// ----------------------------------------------------------------------------
// qmr_sum
// Pipeline stage summing cross products per component, rounding and clamping.
// ----------------------------------------------------------------------------
module qmr_sum import qmr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         valid_in,
   output logic         ready_out,
   input  prod_arr_type prod,
   input  side_type     side_in,
   output logic         valid_out,
   input  logic         ready_in,
   output quat_type     res_out,
   output side_type     side_out
);

   logic                    valid_ff;
   quat_type                res_ff, res_in;
   side_type                side_ff, side_nx_in;
   logic                    enable;
   logic signed [SUM_W-1:0] sum [NUM_COMP];
   rnd_type                 rnd [NUM_COMP];

   function automatic logic signed [SUM_W-1:0] ext(input logic [PROD_W-1:0] v);
      return SUM_W'($signed(v));
   endfunction

   assign enable    = !valid_ff || ready_in;
   assign ready_out = enable;

   always_comb begin
      sum[CX] = ext(prod[CW][CX]) + ext(prod[CX][CW]) + ext(prod[CY][CZ])
              - ext(prod[CZ][CY]);
      sum[CY] = ext(prod[CW][CY]) - ext(prod[CX][CZ]) + ext(prod[CY][CW])
              + ext(prod[CZ][CX]);
      sum[CZ] = ext(prod[CW][CZ]) + ext(prod[CX][CY]) - ext(prod[CY][CX])
              + ext(prod[CZ][CW]);
      sum[CW] = ext(prod[CW][CW]) - ext(prod[CX][CX]) - ext(prod[CY][CY])
              - ext(prod[CZ][CZ]);
      side_nx_in = side_in;
      for (int k = 0; k < NUM_COMP; k++) begin
         rnd[k]    = round_sat(sum[k]);
         res_in[k] = rnd[k].value;
         side_nx_in.sat = side_nx_in.sat | rnd[k].sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && valid_in) begin
         res_ff  <= res_in;
         side_ff <= side_nx_in;
      end
   end

   assign valid_out = valid_ff;
   assign res_out   = res_ff;
   assign side_out  = side_ff;

endmodule

// ===== hdl/quaternion_multiply_rotate.sv =====
// ----------------------------------------------------------------------------
// quaternion_multiply_rotate
// Fixed-point Hamilton product and vector rotation, four-stage pipeline.
// Throughput: one request per cycle unless the response side stalls; every
// request runs both product passes (multiply uses identity in the second),
// each pass a multiply and a sum stage.
// Reset clears the stage valid bits only; datapath registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_multiply_rotate import qmr_pkg::*; (
   input logic       clock,
   input logic       reset,
   qmr_req_if.sink   req,
   qmr_rsp_if.source rsp
);

   quat_type     a_in, t_res, r_res;
   wquat_type    q1_in, q2_in;
   side_type     side0_in, side1, side2, side3, side4;
   prod_arr_type prod1, prod3;
   logic         v1, v2, v3, v4;
   logic         rdy2, rdy3, rdy4;

   always_comb begin
      a_in            = {req.a_w, req.a_z, req.a_y, req.a_x};
      side0_in.opcode = op_type'(req.opcode);
      side0_in.a      = a_in;
      side0_in.sat    = 1'b0;
      q1_in[CX] = WIDE_W'(req.b_x);
      q1_in[CY] = WIDE_W'(req.b_y);
      q1_in[CZ] = WIDE_W'(req.b_z);
      q1_in[CW] = (side0_in.opcode == OP_ROTATE) ? '0 : WIDE_W'(req.b_w);
   end

   qmr_mul u_mul1 (
      .clock, .reset,
      .valid_in (req.valid), .ready_out (req.ready),
      .p (a_in), .q (q1_in), .side_in (side0_in),
      .valid_out (v1), .ready_in (rdy2),
      .prod_out (prod1), .side_out (side1)
   );

   qmr_sum u_sum1 (
      .clock, .reset,
      .valid_in (v1), .ready_out (rdy2),
      .prod (prod1), .side_in (side1),
      .valid_out (v2), .ready_in (rdy3),
      .res_out (t_res), .side_out (side2)
   );

   // rotate: multiply by conj(a), exact in 17 bits; multiply: by identity
   always_comb begin
      if (side2.opcode == OP_ROTATE) begin
         q2_in[CX] = -WIDE_W'($signed(side2.a[CX]));
         q2_in[CY] = -WIDE_W'($signed(side2.a[CY]));
         q2_in[CZ] = -WIDE_W'($signed(side2.a[CZ]));
         q2_in[CW] = WIDE_W'($signed(side2.a[CW]));
      end else begin
         q2_in[CX] = '0;
         q2_in[CY] = '0;
         q2_in[CZ] = '0;
         q2_in[CW] = ONE_VAL;
      end
   end

   qmr_mul u_mul2 (
      .clock, .reset,
      .valid_in (v2), .ready_out (rdy3),
      .p (t_res), .q (q2_in), .side_in (side2),
      .valid_out (v3), .ready_in (rdy4),
      .prod_out (prod3), .side_out (side3)
   );

   qmr_sum u_sum2 (
      .clock, .reset,
      .valid_in (v3), .ready_out (rdy4),
      .prod (prod3), .side_in (side3),
      .valid_out (v4), .ready_in (rsp.ready),
      .res_out (r_res), .side_out (side4)
   );

   assign rsp.valid     = v4;
   assign rsp.res_x     = r_res[CX];
   assign rsp.res_y     = r_res[CY];
   assign rsp.res_z     = r_res[CZ];
   assign rsp.res_w     = r_res[CW];
   assign rsp.saturated = side4.sat;

endmodule

// ===== sim/quaternion_multiply_rotate_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_multiply_rotate_tb
// Self-checking bench for the fixed-point quaternion unit. A directed table
// covers identities, rounding edges, saturation and rotate corner cases.
// Random multiply and rotate requests follow. Every response is checked
// against a known table value or a fixed-point Hamilton product model,
// with random gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module quaternion_multiply_rotate_tb;
   import qmr_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 1800;
   localparam int DRAIN_CYCLES   = 8;

   localparam logic signed [15:0] Q_ZERO = 16'sh0000;
   localparam logic signed [15:0] Q_ONE  = 16'sh1000;
   localparam logic signed [15:0] Q_NONE = 16'shF000;
   localparam logic signed [15:0] Q_TWO  = 16'sh2000;
   localparam logic signed [15:0] Q_HALF = 16'sh0800;
   localparam logic signed [15:0] Q_MAX  = 16'sh7FFF;
   localparam logic signed [15:0] Q_MIN  = 16'sh8000;
   localparam logic signed [15:0] Q_LSB  = 16'sh0001;
   localparam logic signed [15:0] Q_NLSB = 16'shFFFF;

   typedef struct packed {
      op_type             opcode;
      logic signed [15:0] a_x, a_y, a_z, a_w;
      logic signed [15:0] b_x, b_y, b_z, b_w;
   } quat_req_type;

   typedef struct packed {
      logic signed [15:0] res_x, res_y, res_z, res_w;
      logic               saturated;
   } quat_rsp_type;

   typedef struct packed {
      quat_req_type req;
      logic         known;
      quat_rsp_type rsp;
   } dir_row_type;

   typedef longint quad_type [4];

   localparam int NUM_ROWS = 20;
   localparam dir_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{'{OP_MULTIPLY, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO},
        1'b1, '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0}},
      '{'{OP_MULTIPLY, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE},
        1'b1, '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, 1'b0}},
      '{'{OP_MULTIPLY, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO},
        1'b1, '{Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, 1'b0}},
      '{'{OP_MULTIPLY, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX},
        1'b1, '{Q_MAX, Q_MAX, Q_MAX, Q_MIN, 1'b1}},
      '{'{OP_MULTIPLY, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN},
        1'b1, '{Q_MAX, Q_MAX, Q_MAX, Q_MIN, 1'b1}},
      '{'{OP_MULTIPLY, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX},
        1'b1, '{Q_MIN, Q_MIN, Q_MIN, Q_MAX, 1'b1}},
      // rounding: exactly half an lsb goes up, just below half goes down
      '{'{OP_MULTIPLY, Q_ZERO, Q_ZERO, Q_ZERO, Q_LSB, Q_ZERO, Q_ZERO, Q_ZERO, Q_HALF},
        1'b1, '{Q_ZERO, Q_ZERO, Q_ZERO, Q_LSB, 1'b0}},
      '{'{OP_MULTIPLY, Q_ZERO, Q_ZERO, Q_ZERO, Q_NLSB, Q_ZERO, Q_ZERO, Q_ZERO, Q_HALF},
        1'b1, '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0}},
      '{'{OP_MULTIPLY, Q_ZERO, Q_ZERO, Q_ZERO, Q_NLSB, Q_ZERO, Q_ZERO, Q_ZERO,
          16'sh0801}, 1'b1, '{Q_ZERO, Q_ZERO, Q_ZERO, Q_NLSB, 1'b0}},
      // rotate ignores b_w
      '{'{OP_ROTATE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, Q_ONE, Q_TWO, Q_NONE, Q_MAX},
        1'b1, '{Q_ONE, Q_TWO, Q_NONE, Q_ZERO, 1'b0}},
      '{'{OP_ROTATE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, Q_ONE, Q_TWO, Q_NONE, Q_MIN},
        1'b1, '{Q_ONE, Q_TWO, Q_NONE, Q_ZERO, 1'b0}},
      // conjugate of the most negative component enters as +32768
      '{'{OP_ROTATE, Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO},
        1'b1, '{Q_ZERO, Q_MIN, Q_ZERO, Q_ZERO, 1'b1}},
      '{'{OP_ROTATE, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX},
        1'b0, '0},
      '{'{OP_ROTATE, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN},
        1'b0, '0},
      '{'{OP_ROTATE, Q_ZERO, Q_ZERO, 16'sh0B50, 16'sh0B50, Q_ONE, Q_ZERO, Q_ZERO,
          Q_ZERO}, 1'b0, '0},
      '{'{OP_ROTATE, Q_ZERO, Q_ZERO, Q_ZERO, Q_MAX, 16'sh0100, 16'shFF00, Q_ONE,
          Q_ZERO}, 1'b0, '0},
      '{'{OP_MULTIPLY, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'shAAAA,
          16'sh5555, 16'shAAAA, 16'sh5555}, 1'b0, '0},
      '{'{OP_MULTIPLY, 16'sh03E8, 16'sh07D0, 16'shF448, Q_HALF, 16'shFC18,
          16'shF830, 16'sh0BB8, Q_HALF}, 1'b0, '0},
      '{'{OP_ROTATE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO},
        1'b1, '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0}},
      '{'{OP_MULTIPLY, Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO, Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO},
        1'b1, '{Q_ZERO, Q_ZERO, Q_ZERO, Q_MIN, 1'b1}}
   };

   logic clock = 1'b0;
   logic reset;

   qmr_req_if req_if ();
   qmr_rsp_if rsp_if ();

   quat_rsp_type pending_rsp [$];
   quat_rsp_type next_rsp;
   int           err_cnt     = 0;
   int           rsp_cnt     = 0;
   int           idle_cycles = 0;
   int           cycle_cnt   = 0;
   int           stall_left  = 0;

   quaternion_multiply_rotate u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   always #4 clock = ~clock;

   function automatic longint round_clamp(input longint s, inout logic sat);
      longint r;
      r = (s + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (r > 32767) begin
         sat = 1'b1;
         return 32767;
      end
      if (r < -32768) begin
         sat = 1'b1;
         return -32768;
      end
      return r;
   endfunction

   // components ordered x, y, z, w
   function automatic void hamilton_wide(input quad_type p, input quad_type q,
                                         output quad_type r, inout logic sat);
      r[0] = round_clamp(p[3]*q[0] + p[0]*q[3] + p[1]*q[2] - p[2]*q[1], sat);
      r[1] = round_clamp(p[3]*q[1] - p[0]*q[2] + p[1]*q[3] + p[2]*q[0], sat);
      r[2] = round_clamp(p[3]*q[2] + p[0]*q[1] - p[1]*q[0] + p[2]*q[3], sat);
      r[3] = round_clamp(p[3]*q[3] - p[0]*q[0] - p[1]*q[1] - p[2]*q[2], sat);
   endfunction

   function automatic quat_rsp_type predict_quat(input quat_req_type q);
      quad_type     a, b, t, c, r;
      logic         sat;
      quat_rsp_type p;
      sat = 1'b0;
      a   = '{q.a_x, q.a_y, q.a_z, q.a_w};
      b   = '{q.b_x, q.b_y, q.b_z, q.b_w};
      if (q.opcode == OP_MULTIPLY) begin
         hamilton_wide(a, b, r, sat);
      end else begin
         b[3] = 0;
         hamilton_wide(a, b, t, sat);
         c = '{-a[0], -a[1], -a[2], a[3]};
         hamilton_wide(t, c, r, sat);
      end
      p.res_x     = 16'(r[0]);
      p.res_y     = 16'(r[1]);
      p.res_z     = 16'(r[2]);
      p.res_w     = 16'(r[3]);
      p.saturated = sat;
      return p;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic logic signed [15:0] rand_comp();
      unique case ($urandom_range(0, 9))
         0, 1, 2, 3: return 16'($urandom_range(0, 8192) - 4096);
         4, 5:       return 16'($urandom_range(0, 16384) - 8192);
         6, 7:       return 16'($urandom);
         8: begin
            unique case ($urandom_range(0, 6))
               0:       return Q_MAX;
               1:       return Q_MIN;
               2:       return Q_ZERO;
               3:       return Q_LSB;
               4:       return Q_NLSB;
               5:       return Q_ONE;
               default: return Q_NONE;
            endcase
         end
         default: return 16'($urandom_range(0, 32) - 16);
      endcase
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      err_cnt++;
   endtask

   task automatic send_quat(input quat_req_type q, input quat_rsp_type want,
                            input bit no_gap);
      int gap;
      gap = no_gap ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      next_rsp       = want;
      req_if.valid  <= 1'b1;
      req_if.opcode <= q.opcode;
      req_if.a_x    <= q.a_x;
      req_if.a_y    <= q.a_y;
      req_if.a_z    <= q.a_z;
      req_if.a_w    <= q.a_w;
      req_if.b_x    <= q.b_x;
      req_if.b_y    <= q.b_y;
      req_if.b_z    <= q.b_z;
      req_if.b_w    <= q.b_w;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // response-side stalls, with stretches of steady ready
   always @(negedge clock) begin
      int gap;
      cycle_cnt++;
      if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left--;
      end else if ((cycle_cnt / 400) % 3 == 1) begin
         rsp_if.ready <= 1'b1;
      end else begin
         gap = pick_gap();
         rsp_if.ready <= (gap == 0);
         if (gap > 0) stall_left = gap - 1;
      end
   end

   always @(posedge clock) begin
      quat_rsp_type got, want;
      if (!reset) begin
         idle_cycles++;
         if (req_if.valid && req_if.ready) begin
            pending_rsp = {pending_rsp, next_rsp};
            idle_cycles = 0;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            idle_cycles = 0;
            got = '{rsp_if.res_x, rsp_if.res_y, rsp_if.res_z, rsp_if.res_w,
                    rsp_if.saturated};
            if (pending_rsp.size() == 0) begin
               report_error("response with no request outstanding");
            end else begin
               want = pending_rsp.pop_front();
               if (got.res_x !== want.res_x)
                  report_error($sformatf("rsp %0d res_x got %0d want %0d",
                                         rsp_cnt, got.res_x, want.res_x));
               if (got.res_y !== want.res_y)
                  report_error($sformatf("rsp %0d res_y got %0d want %0d",
                                         rsp_cnt, got.res_y, want.res_y));
               if (got.res_z !== want.res_z)
                  report_error($sformatf("rsp %0d res_z got %0d want %0d",
                                         rsp_cnt, got.res_z, want.res_z));
               if (got.res_w !== want.res_w)
                  report_error($sformatf("rsp %0d res_w got %0d want %0d",
                                         rsp_cnt, got.res_w, want.res_w));
               if (got.saturated !== want.saturated)
                  report_error($sformatf("rsp %0d saturated got %b want %b",
                                         rsp_cnt, got.saturated, want.saturated));
            end
            rsp_cnt++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("quaternion_multiply_rotate_tb NOT OK");
            $finish;
         end
      end
   end

   initial begin
      quat_req_type q;
      reset         = 1'b1;
      rsp_if.ready  = 1'b0;
      req_if.valid  = 1'b0;
      req_if.opcode = 1'b0;
      req_if.a_x    = '0;
      req_if.a_y    = '0;
      req_if.a_z    = '0;
      req_if.a_w    = '0;
      req_if.b_x    = '0;
      req_if.b_y    = '0;
      req_if.b_z    = '0;
      req_if.b_w    = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         send_quat(DIRECTED_ROWS[i].req,
                   DIRECTED_ROWS[i].known ? DIRECTED_ROWS[i].rsp
                                          : predict_quat(DIRECTED_ROWS[i].req),
                   i % 2 == 0);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         q.opcode = $urandom_range(0, 1) ? OP_ROTATE : OP_MULTIPLY;
         q.a_x    = rand_comp();
         q.a_y    = rand_comp();
         q.a_z    = rand_comp();
         q.a_w    = rand_comp();
         q.b_x    = rand_comp();
         q.b_y    = rand_comp();
         q.b_z    = rand_comp();
         q.b_w    = rand_comp();
         send_quat(q, predict_quat(q), (i % 300) < 100);
      end
      req_if.valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_cnt == 0) begin
         $display("quaternion_multiply_rotate_tb OK");
      end else begin
         $display("quaternion_multiply_rotate_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== quaternion_multiply_rotate.f =====
hdl/qmr_pkg.sv
hdl/qmr_if.sv
hdl/qmr_mul.sv
hdl/qmr_sum.sv
hdl/quaternion_multiply_rotate.sv
sim/quaternion_multiply_rotate_tb.sv
